>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define AST_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside of reset.
`define AST_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hw/rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared widths, operation and status codes, and the control/status structs
// that join the chain table controller and datapath.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int DATA_W      = 16;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int MAX_RESULTS = 64;
  localparam int BLOCKS_DEF  = 64;
  localparam int TERM_DEF    = 65535;

  // operations
  localparam logic [OP_W-1:0] OP_WALK   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_LINK   = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd4;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd5;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd6;
  localparam logic [OP_W-1:0] OP_READ   = 3'd7;

  // result status
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_TERM = 2'd1;
  localparam logic [ST_W-1:0] ST_OOR  = 2'd2;
  localparam logic [ST_W-1:0] ST_LOOP = 2'd3;

  // result value select
  localparam logic [1:0] OSEL_CUR   = 2'd0;
  localparam logic [1:0] OSEL_NXT   = 2'd1;
  localparam logic [1:0] OSEL_IDX   = 2'd2;
  localparam logic [1:0] OSEL_ENTRY = 2'd3;

  typedef struct packed {
    logic            load;     // capture input word, cur <= index
    logic            restart;  // cur <= stored index, count <= 0
    logic            step;     // cur <= link read, count++
    logic            emit;     // load output register
    logic [1:0]      osel;
    logic            olast;
    logic [ST_W-1:0] ostat;
    logic            wr;       // table write at cur (or sweep pointer)
    logic            wr_term;  // write data is the terminator, else value
    logic            clr;      // reset sweep: address is sweep pointer
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_term;
    logic            idx_oor;
    logic            self_link;  // stored index equals stored value
    logic            nxt_term;
    logic            nxt_oor;
    logic            limit;
    logic            clr_last;
    logic            out_free;
  } stat_t;

endpackage

>>> hw/rtl/fct_req_if.sv
// ----------------------------------------------------------------------------
// fct_req_if / fct_rsp_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface fct_req_if;
  import fct_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] block_index;
  logic [DATA_W-1:0] entry_value;

  modport source (output valid, output operation, output block_index,
                  output entry_value, input ready);
  modport sink   (input valid, input operation, input block_index,
                  input entry_value, output ready);
endinterface

interface fct_rsp_if;
  import fct_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] block_value;
  logic              last;
  logic [ST_W-1:0]   status;

  modport source (output valid, output block_value, output last,
                  output status, input ready);
  modport sink   (input valid, input block_value, input last,
                  input status, output ready);
endinterface

>>> hw/rtl/fct_ram.sv
// ----------------------------------------------------------------------------
// fct_ram
// Generic single-clock RAM, one write and one read address, registered read.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fct_dp.sv
// ----------------------------------------------------------------------------
// fct_dp
// Chain table datapath: link table RAM, chain pointer and step count,
// reset sweep pointer, result register, and the compares fed to control.
// ----------------------------------------------------------------------------
module fct_dp #(
  parameter int BLOCKS     = fct_pkg::BLOCKS_DEF,
  parameter int TERMINATOR = fct_pkg::TERM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fct_pkg::cmd_t               cmd,
  output fct_pkg::stat_t              stat,
  input  logic [fct_pkg::OP_W-1:0]    operation,
  input  logic [fct_pkg::DATA_W-1:0]  block_index,
  input  logic [fct_pkg::DATA_W-1:0]  entry_value,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [fct_pkg::DATA_W-1:0]  block_value,
  output logic                        last,
  output logic [fct_pkg::ST_W-1:0]    status
);
  import fct_pkg::*;

  localparam int AW         = $clog2(BLOCKS);
  localparam int WALK_LIMIT = (BLOCKS < MAX_RESULTS) ? BLOCKS : MAX_RESULTS;
  localparam int CW         = $clog2(WALK_LIMIT);
  localparam logic [DATA_W-1:0] TERM_V = DATA_W'(TERMINATOR);
  localparam logic [DATA_W-1:0] BLK_V  = DATA_W'(BLOCKS);

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] idx_q;
  logic [DATA_W-1:0] val_q;
  logic [AW-1:0]     cur;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     clr_ptr;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] entry;
  logic [DATA_W-1:0] res_val;

  assign ram_we    = cmd.wr;
  assign ram_addr  = cmd.clr ? clr_ptr : cur;
  assign ram_wdata = cmd.wr_term ? TERM_V : val_q;

  fct_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      idx_q <= block_index;
      val_q <= entry_value;
      cur   <= block_index[AW-1:0];
      cnt   <= '0;
    end else if (cmd.restart) begin
      cur <= idx_q[AW-1:0];
      cnt <= '0;
    end else if (cmd.step) begin
      cur <= ram_rdata[AW-1:0];
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr) begin
      clr_ptr <= clr_ptr + AW'(1);
    end
  end

  // entry as it stands after a single-entry operation
  always_comb begin
    case (op_q)
      OP_LINK:  entry = (idx_q == val_q) ? ram_rdata : val_q;
      OP_MARK:  entry = TERM_V;
      OP_WRITE: entry = val_q;
      default:  entry = ram_rdata;
    endcase
  end

  always_comb begin
    case (cmd.osel)
      OSEL_CUR: res_val = DATA_W'(cur);
      OSEL_NXT: res_val = ram_rdata;
      OSEL_IDX: res_val = idx_q;
      default:  res_val = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      block_value <= res_val;
      last        <= cmd.olast;
      status      <= cmd.ostat;
    end
  end

  assign stat.op        = op_q;
  assign stat.idx_term  = (idx_q == TERM_V);
  assign stat.idx_oor   = (idx_q >= BLK_V);
  assign stat.self_link = (idx_q == val_q);
  assign stat.nxt_term  = (ram_rdata == TERM_V);
  assign stat.nxt_oor   = (ram_rdata >= BLK_V);
  assign stat.limit     = (cnt == CW'(WALK_LIMIT - 1));
  assign stat.clr_last  = (clr_ptr == AW'(BLOCKS - 1));
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

>>> hw/rtl/fct_ctl.sv
// ----------------------------------------------------------------------------
// fct_ctl
// Chain table controller: reset sweep, input checks, chain walk with
// result emission, free-chain clearing pass and single-entry operations.
// ----------------------------------------------------------------------------
module fct_ctl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fct_pkg::stat_t stat,
  output fct_pkg::cmd_t  cmd
);
  import fct_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_BAD  = 4'd5;
  localparam logic [3:0] S_FRD  = 4'd6;
  localparam logic [3:0] S_FEV  = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SEX  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       is_free;
  logic       silent;

  assign is_free = (stat.op == OP_FREE);
  assign silent  = (stat.op == OP_APPEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      S_CLR: begin
        cmd.wr      = 1'b1;
        cmd.wr_term = 1'b1;
        cmd.clr     = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.idx_term && stat.op inside {[OP_WALK:OP_NEXT]}) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.osel   = OSEL_IDX;
            cmd.olast  = 1'b1;
            cmd.ostat  = ST_TERM;
            state_next = S_IDLE;
          end
        end else if (stat.idx_oor) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.osel   = OSEL_IDX;
            cmd.olast  = 1'b1;
            cmd.ostat  = ST_OOR;
            state_next = S_IDLE;
          end
        end else if (stat.op inside {OP_WALK, OP_FREE, OP_APPEND}) begin
          state_next = S_RD;
        end else begin
          state_next = S_SRD;
        end
      end
      S_RD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.nxt_term) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.osel    = OSEL_CUR;
            cmd.olast   = 1'b1;
            cmd.ostat   = ST_OK;
            cmd.wr      = silent;  // append links the value at the tail
            cmd.restart = is_free;
            state_next  = is_free ? S_FRD : S_IDLE;
          end
        end else if (stat.limit) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.osel    = silent ? OSEL_IDX : OSEL_CUR;
            cmd.olast   = 1'b1;
            cmd.ostat   = ST_LOOP;
            cmd.restart = is_free;
            state_next  = is_free ? S_FRD : S_IDLE;
          end
        end else if (stat.nxt_oor) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (silent) begin
              cmd.osel   = OSEL_IDX;
              cmd.olast  = 1'b1;
              cmd.ostat  = ST_OOR;
              state_next = S_IDLE;
            end else begin
              cmd.osel   = OSEL_CUR;
              cmd.ostat  = ST_OK;
              state_next = S_BAD;
            end
          end
        end else if (silent) begin
          cmd.step   = 1'b1;
          state_next = S_RD;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.osel   = OSEL_CUR;
          cmd.ostat  = ST_OK;
          cmd.step   = 1'b1;
          state_next = S_RD;
        end
      end
      S_BAD: begin
        // read data still holds the bad link: cur is unchanged
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.osel    = OSEL_NXT;
          cmd.olast   = 1'b1;
          cmd.ostat   = ST_OOR;
          cmd.restart = is_free;
          state_next  = is_free ? S_FRD : S_IDLE;
        end
      end
      S_FRD: begin
        state_next = S_FEV;
      end
      S_FEV: begin
        // second pass; a revisited block already reads as terminator
        cmd.wr      = 1'b1;
        cmd.wr_term = 1'b1;
        if (stat.nxt_term || stat.nxt_oor || stat.limit) begin
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_FRD;
        end
      end
      S_SRD: begin
        state_next = S_SEX;
      end
      S_SEX: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.osel    = OSEL_ENTRY;
          cmd.olast   = 1'b1;
          cmd.ostat   = ST_OK;
          cmd.wr_term = (stat.op == OP_MARK);
          cmd.wr      = (stat.op == OP_MARK) || (stat.op == OP_WRITE) ||
                        ((stat.op == OP_LINK) && !stat.self_link);
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/fat_chain_table_engine_unit.sv
// ----------------------------------------------------------------------------
// fat_chain_table_engine_unit
// File allocation table of next-block links with chain walk, free, append
// and single-entry set/get operations.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation word (operation, block_index, entry_value);
//   rsp returns result words (block_value, last, status), last=1 on the
//   final word of each operation. Both are valid/ready channels.
//   After reset the link table is swept to the terminator, one entry per
//   cycle: req.ready stays low until the sweep is done.
//   One operation is worked at a time. An input error is reported from the
//   check state; a single-entry operation reads the entry, then emits and
//   writes it. A walk reads each chain block from RAM, then compares and
//   emits it, and an extra state emits the bad link when the walk ends on
//   one; append walks the same way but emits only its final word. Free
//   chain adds a second clearing pass that reads and clears each block.
//   Results pass through one output register; a new operation is taken
//   while the last result still waits there. When rsp stalls, the walk
//   holds in place until the output register frees.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_unit #(
  parameter int BLOCKS     = fct_pkg::BLOCKS_DEF,
  parameter int TERMINATOR = fct_pkg::TERM_DEF
) (
  input logic        clk,
  input logic        rst,
  fct_req_if.sink    req,
  fct_rsp_if.source  rsp
);
  import fct_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fct_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fct_dp #(
    .BLOCKS     (BLOCKS),
    .TERMINATOR (TERMINATOR)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (req.operation),
    .block_index (req.block_index),
    .entry_value (req.entry_value),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .block_value (rsp.block_value),
    .last        (rsp.last),
    .status      (rsp.status)
  );

endmodule

>>> hw/rtl/fct_chk.sv
// ----------------------------------------------------------------------------
// fct_chk
// Port-level checks for the chain table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fct_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [fct_pkg::DATA_W-1:0] rsp_block_value,
  input logic                       rsp_last,
  input logic [fct_pkg::ST_W-1:0]   rsp_status
);
  import fct_pkg::*;

  localparam int RCW = $clog2(MAX_RESULTS + 1);

  logic           in_acc;
  logic           out_acc;
  logic [1:0]     pending;
  logic [RCW-1:0] rcount;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  // operations accepted whose final word is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc && rsp_last);
    end
  end

  // words delivered so far for the current operation
  always_ff @(posedge clk) begin
    if (rst) begin
      rcount <= '0;
    end else if (out_acc) begin
      rcount <= rsp_last ? '0 : rcount + RCW'(1);
    end
  end

  `AST_HOLDS(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_block_value, rsp_last, rsp_status}), "result word changed while stalled")
  `AST_NEVER(a_no_orphan, clk, rst, out_acc && (pending == 2'd0), "result word with no operation outstanding")
  `AST_HOLDS(a_err_last, clk, rst, rsp_valid && (rsp_status != ST_OK) |-> rsp_last, "error status on a non-final word")
  `AST_NEVER(a_max_words, clk, rst, out_acc && !rsp_last && (rcount >= RCW'(MAX_RESULTS - 1)), "too many result words for one operation")

endmodule

bind fat_chain_table_engine_unit fct_chk u_fct_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_block_value (rsp.block_value),
  .rsp_last        (rsp.last),
  .rsp_status      (rsp.status)
);

>>> sim/tb_fat_chain_table_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_fat_chain_table_engine_unit
// Self-checking bench for the chain table engine. Operation words go in from
// a queue with random gaps; each result word is compared with a link table
// model kept in the bench. The result side stalls at random and once for a
// long stretch so that the engine backs up and holds off new operations.
// ----------------------------------------------------------------------------
module tb_fat_chain_table_engine_unit;
  import fct_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int BLOCKS     = BLOCKS_DEF;
  localparam int TERMINATOR = TERM_DEF;
  localparam int STEP_LIMIT = (BLOCKS < MAX_RESULTS) ? BLOCKS : MAX_RESULTS;
  localparam logic [DATA_W-1:0] TERM_WORD = DATA_W'(TERMINATOR);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] index;
    logic [DATA_W-1:0] value;
    logic [3:0]        gap;
  } op_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic [ST_W-1:0]   status;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fct_req_if req_bus();
  fct_rsp_if rsp_bus();

  fat_chain_table_engine_unit #(
    .BLOCKS(BLOCKS),
    .TERMINATOR(TERMINATOR)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  logic [DATA_W-1:0] link_model [BLOCKS];
  op_word_t          pending_ops[$];
  result_word_t      expected_words[$];
  result_word_t      chain_words[$];

  int ops_queued    = 0;
  int ops_taken     = 0;
  int words_checked = 0;
  int fail_count    = 0;
  int loops_seen    = 0;
  int oor_seen      = 0;
  int send_gap      = 0;
  int recv_wait     = 0;
  int hold_left     = 0;
  bit long_hold_done = 1'b0;
  bit idle_free      = 1'b0;
  bit op_accepted    = 1'b0;
  bit word_accepted  = 1'b0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  task automatic add_chain_word(input result_word_t w);
    chain_words = {chain_words, w};
  endtask

  task automatic add_expected(input result_word_t w);
    expected_words = {expected_words, w};
  endtask

  // Follows a chain in the model; leaves its words in chain_words.
  task automatic trace_chain(input logic [DATA_W-1:0] start,
                             output logic [DATA_W-1:0] tail,
                             output logic [ST_W-1:0] st);
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] nxt;
    result_word_t      w;
    bit                done;
    chain_words.delete();
    tail = start;
    st   = ST_OK;
    if (start == TERM_WORD) begin
      add_chain_word('{start, 1'b1, ST_TERM});
      st = ST_TERM;
    end else if (start >= BLOCKS) begin
      add_chain_word('{start, 1'b1, ST_OOR});
      st = ST_OOR;
    end else begin
      cur  = start;
      done = 1'b0;
      while (!done) begin
        w   = '{cur, 1'b0, ST_OK};
        nxt = link_model[cur];
        if (nxt == TERM_WORD) begin
          w.last = 1'b1;
          add_chain_word(w);
          done = 1'b1;
        end else if (chain_words.size() + 1 >= STEP_LIMIT) begin
          // step budget spent with links still going: a loop
          w.last   = 1'b1;
          w.status = ST_LOOP;
          add_chain_word(w);
          st   = ST_LOOP;
          done = 1'b1;
        end else if (nxt >= BLOCKS) begin
          add_chain_word(w);
          add_chain_word('{nxt, 1'b1, ST_OOR});
          st   = ST_OOR;
          done = 1'b1;
        end else begin
          add_chain_word(w);
          cur = nxt;
        end
      end
      tail = cur;
    end
  endtask

  task automatic apply_operation(input op_word_t item);
    logic [DATA_W-1:0] tail;
    logic [ST_W-1:0]   st;
    case (item.op)
      OP_WALK, OP_FREE: begin
        trace_chain(item.index, tail, st);
        foreach (chain_words[k]) begin
          add_expected(chain_words[k]);
          // free sets visited blocks to the terminator, not to zero
          if (item.op == OP_FREE && chain_words[k].value < BLOCKS &&
              chain_words[k].value != TERM_WORD)
            link_model[chain_words[k].value] = TERM_WORD;
        end
      end
      OP_APPEND: begin
        trace_chain(item.index, tail, st);
        if (st == ST_OK) begin
          link_model[tail] = item.value;
          add_expected('{tail, 1'b1, ST_OK});
        end else begin
          add_expected('{item.index, 1'b1, st});
        end
      end
      default: begin
        if (item.op <= OP_NEXT && item.index == TERM_WORD) begin
          add_expected('{item.index, 1'b1, ST_TERM});
        end else if (item.index >= BLOCKS) begin
          add_expected('{item.index, 1'b1, ST_OOR});
        end else begin
          case (item.op)
            OP_LINK:  if (item.index != item.value) link_model[item.index] = item.value;
            OP_MARK:  link_model[item.index] = TERM_WORD;
            OP_WRITE: link_model[item.index] = item.value;
            default:  ;
          endcase
          add_expected('{link_model[item.index], 1'b1, ST_OK});
        end
      end
    endcase
  endtask

  task automatic queue_op(input logic [OP_W-1:0] op, input int index, input int value);
    op_word_t item;
    item.op    = op;
    item.index = DATA_W'(index);
    item.value = DATA_W'(value);
    item.gap   = idle_free ? 4'd0 : 4'($urandom_range(0, 12));
    pending_ops = {pending_ops, item};
  endtask

  // mostly valid blocks, with terminator, just-out-of-range and wild indices
  function automatic int pick_index();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return TERMINATOR;
    if (r == 1) return $urandom_range(0, 65535);
    if (r == 2) return $urandom_range(BLOCKS, BLOCKS + 3);
    return $urandom_range(0, BLOCKS - 1);
  endfunction

  function automatic int pick_link();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return TERMINATOR;
    if (r == 2) return $urandom_range(0, 65535);
    return $urandom_range(0, BLOCKS - 1);
  endfunction

  // driver: operation words, presented at the falling edge
  always @(negedge clk) begin
    op_word_t item;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || op_accepted) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        req_bus.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        item = pending_ops.pop_front();
        req_bus.valid       <= 1'b1;
        req_bus.operation   <= item.op;
        req_bus.block_index <= item.index;
        req_bus.entry_value <= item.value;
        send_gap            <= item.gap;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // result side ready: random wait per word, calm stretches, one long hold
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (!long_hold_done && ops_taken >= 60) begin
        hold_left      = 400;
        long_hold_done = 1'b1;
      end
      if (word_accepted)
        recv_wait = ((words_checked / 80) % 3 == 2) ? 0 : $urandom_range(0, 12);
      if (hold_left > 0) begin
        hold_left     = hold_left - 1;
        rsp_bus.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait     = recv_wait - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // monitor: results are checked before the new operation is predicted, since
  // a word leaving at this edge belongs to an earlier operation
  always @(posedge clk) begin
    result_word_t want;
    op_word_t     got_op;
    word_accepted <= !rst && rsp_bus.valid && rsp_bus.ready;
    op_accepted   <= !rst && req_bus.valid && req_bus.ready;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        words_checked = words_checked + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected result word: block_value %0d last %0d status %0d",
                 rsp_bus.block_value, rsp_bus.last, rsp_bus.status);
          fail_count = fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (rsp_bus.block_value !== want.value) begin
            $error("block_value: expected %0d, got %0d", want.value, rsp_bus.block_value);
            fail_count = fail_count + 1;
          end
          if (rsp_bus.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
            fail_count = fail_count + 1;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            fail_count = fail_count + 1;
          end
          if (want.status == ST_LOOP) loops_seen = loops_seen + 1;
          if (want.status == ST_OOR) oor_seen = oor_seen + 1;
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        ops_taken    = ops_taken + 1;
        got_op.op    = req_bus.operation;
        got_op.index = req_bus.block_index;
        got_op.value = req_bus.entry_value;
        got_op.gap   = 4'd0;
        apply_operation(got_op);
      end
    end
  end

  initial begin
    int k;
    int len;
    int base;
    int stride;
    int tail_blk;
    int random_goal;
    req_bus.valid       = 1'b0;
    req_bus.operation   = OP_WALK;
    req_bus.block_index = '0;
    req_bus.entry_value = '0;
    rsp_bus.ready       = 1'b0;
    for (k = 0; k < BLOCKS; k++) link_model[k] = TERM_WORD;

    // directed part
    queue_op(OP_READ, 0, 0);
    queue_op(OP_WALK, 0, 65535);
    queue_op(OP_WALK, TERMINATOR, 0);
    queue_op(OP_WALK, BLOCKS, 0);
    queue_op(OP_FREE, TERMINATOR, 0);
    queue_op(OP_APPEND, 16'hFFFE, 0);
    queue_op(OP_LINK, TERMINATOR, 3);
    queue_op(OP_MARK, TERMINATOR, 0);
    queue_op(OP_NEXT, TERMINATOR, 0);
    queue_op(OP_WRITE, TERMINATOR, 0);
    queue_op(OP_READ, BLOCKS, 0);
    queue_op(OP_LINK, 5, 5);            // self-link is dropped
    queue_op(OP_LINK, 1, 2);
    queue_op(OP_LINK, 2, 3);
    queue_op(OP_APPEND, 1, 7);
    queue_op(OP_WALK, 1, 0);
    queue_op(OP_NEXT, 3, 0);
    queue_op(OP_WRITE, 7, 16'h8000);    // bad link inside the chain
    queue_op(OP_WALK, 1, 0);
    queue_op(OP_APPEND, 1, 9);
    queue_op(OP_WRITE, 7, 1);           // close the chain into a loop
    queue_op(OP_WALK, 1, 0);
    queue_op(OP_APPEND, 1, 9);
    queue_op(OP_FREE, 1, 0);
    queue_op(OP_NEXT, 3, 0);
    queue_op(OP_WRITE, BLOCKS - 1, 0);
    queue_op(OP_MARK, BLOCKS - 1, 65535);

    // random part: mostly chains built from links, then worked on
    random_goal = pending_ops.size() + 200;
    while (pending_ops.size() < random_goal) begin
      idle_free = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        len      = $urandom_range(1, 8);
        base     = $urandom_range(0, BLOCKS - 1);
        stride   = 2 * $urandom_range(0, BLOCKS / 2 - 1) + 1;
        for (k = 0; k < len - 1; k++)
          queue_op(OP_LINK, (base + k * stride) % BLOCKS, (base + (k + 1) * stride) % BLOCKS);
        tail_blk = (base + (len - 1) * stride) % BLOCKS;
        if ($urandom_range(0, 1))
          queue_op(OP_MARK, tail_blk, $urandom_range(0, 65535));
        else
          queue_op(OP_WRITE, tail_blk, TERMINATOR);
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 5))
            0, 1:    queue_op(OP_WALK, base, $urandom_range(0, 65535));
            2:       queue_op(OP_APPEND, base, pick_link());
            3:       queue_op(OP_FREE, base, $urandom_range(0, 65535));
            4:       queue_op(OP_NEXT, (base + stride) % BLOCKS, 0);
            default: queue_op(OP_READ, base, $urandom_range(0, 65535));
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 4))
          queue_op(OP_W'($urandom_range(0, 7)), pick_index(), pick_link());
      end
    end
    ops_queued = pending_ops.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_taken < ops_queued || expected_words.size() != 0) @(negedge clk);
    // a free over a long chain still sweeps after its last word
    repeat (300) @(negedge clk);

    $display("Covered %0d operations and %0d result words, %0d of them chain loops",
             ops_taken, words_checked, loops_seen);
    $display("and %0d out-of-range reports; %0d mismatches.", oor_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 1500000);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/fct_pkg.sv
hw/rtl/fct_req_if.sv
hw/rtl/fct_ram.sv
hw/rtl/fct_dp.sv
hw/rtl/fct_ctl.sv
hw/rtl/fat_chain_table_engine_unit.sv
hw/rtl/fct_chk.sv
sim/tb_fat_chain_table_engine_unit.sv
